>>> sv/i2cram_pkg.sv
// shared types and constants for the i2c register access master
// no dependencies; used by i2cram_front, i2cram_seq and the top level
package i2cram_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  localparam logic [6:0]  RESET_DEV_ADDR    = 7'd28;
  localparam logic [15:0] RESET_PHASE_TICKS = 16'd5;

  // configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_PHASE_TICKS    = 1'b1;

  // input action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // read/write bit appended to the device address
  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_WRITE,
    KIND_READ
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] phase_ticks;
  } cfg_t;

endpackage

>>> sv/i2cram_front.sv
// front end: accepts input beats, decodes the action and queues the item
// depends on i2cram_pkg
module i2cram_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_reg_address,
  input  logic [7:0]         in_write_data,
  input  logic               in_sda_in,
  output logic               q_valid,
  output i2cram_pkg::item_t  q_item,
  input  logic               q_pop
);

  i2cram_pkg::item_t                      entry_r [i2cram_pkg::QueueDepth];
  logic [i2cram_pkg::QueuePtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [i2cram_pkg::QueuePtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [i2cram_pkg::QueuePtrW:0]         count_r, count_nxt;
  i2cram_pkg::item_t                      item;
  logic                                   push;
  logic                                   pop;

  // action 3 counts as a plain tick
  always_comb begin
    item.reg_address = in_reg_address;
    item.write_data  = in_write_data;
    item.sda_in      = in_sda_in;
    case (in_action)
      i2cram_pkg::ACT_WRITE: item.kind = i2cram_pkg::KIND_WRITE;
      i2cram_pkg::ACT_READ:  item.kind = i2cram_pkg::KIND_READ;
      default:               item.kind = i2cram_pkg::KIND_TICK;
    endcase
  end

  assign in_ready = (count_r != (i2cram_pkg::QueuePtrW+1)'(i2cram_pkg::QueueDepth));
  assign q_valid  = (count_r != '0);
  assign q_item   = entry_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item;
    end
  end

endmodule

>>> sv/i2cram_seq.sv
// back end: bus sequencer, one queued item per tick, and the output register
// depends on i2cram_pkg
module i2cram_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  i2cram_pkg::cfg_t   cfg,
  input  logic               q_valid,
  input  i2cram_pkg::item_t  q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_scl_level,
  output logic               out_sda_level,
  output logic               out_sda_drive,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic [7:0]         out_read_data
);

  typedef enum logic [3:0] {
    SEG_IDLE   = 4'd0,
    SEG_START1 = 4'd1,
    SEG_ADDR_W = 4'd2,
    SEG_REG    = 4'd3,
    SEG_DATA   = 4'd4,
    SEG_START2 = 4'd5,
    SEG_ADDR_R = 4'd6,
    SEG_READ   = 4'd7,
    SEG_STOP   = 4'd8
  } seg_t;

  seg_t        seg_r, seg_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        is_read_r, is_read_nxt;
  logic [7:0]  held_reg_r, held_reg_nxt;
  logic [7:0]  held_data_r, held_data_nxt;
  logic [7:0]  recv_r, recv_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        drv_r, drv_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  rdata_r, rdata_nxt;

  logic [16:0] tick_inc;
  logic [16:0] limit;
  logic [3:0]  bit_inc;
  logic        idle;
  logic        bit_out;

  assign q_pop    = q_valid && (!out_valid_r || out_ready);
  assign tick_inc = {1'b0, tick_r} + 17'd1;
  assign limit    = (cfg.phase_ticks == '0) ? 17'd1 : {1'b0, cfg.phase_ticks};
  assign bit_inc  = bit_count_r + 4'd1;
  assign idle     = (seg_r == SEG_IDLE) && (ph_r == 2'd0);

  always_comb begin
    seg_nxt       = seg_r;
    ph_nxt        = ph_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    tick_nxt      = tick_r;
    is_read_nxt   = is_read_r;
    held_reg_nxt  = held_reg_r;
    held_data_nxt = held_data_r;
    recv_nxt      = recv_r;
    done_nxt      = 1'b0;

    if (q_pop) begin
      if (idle) begin
        if (q_item.kind != i2cram_pkg::KIND_TICK) begin
          is_read_nxt   = (q_item.kind == i2cram_pkg::KIND_READ);
          held_reg_nxt  = q_item.reg_address;
          if (q_item.kind == i2cram_pkg::KIND_WRITE) begin
            held_data_nxt = q_item.write_data;
          end
          seg_nxt       = SEG_START1;
          ph_nxt        = 2'd0;
          bit_count_nxt = 4'd0;
          tick_nxt      = 16'd0;
        end
      end else if (tick_inc < limit) begin
        tick_nxt = tick_inc[15:0];
      end else begin
        tick_nxt = 16'd0;
        case (seg_r)
          SEG_START1, SEG_START2: begin
            if (ph_r != 2'd3) begin
              ph_nxt = ph_r + 2'd1;
            end else begin
              ph_nxt        = 2'd0;
              bit_count_nxt = 4'd0;
              if (seg_r == SEG_START1) begin
                seg_nxt   = SEG_ADDR_W;
                shift_nxt = {cfg.device_address, i2cram_pkg::RW_WRITE};
              end else begin
                seg_nxt   = SEG_ADDR_R;
                shift_nxt = {cfg.device_address, i2cram_pkg::RW_READ};
              end
            end
          end
          SEG_ADDR_W, SEG_REG, SEG_DATA, SEG_ADDR_R: begin
            case (ph_r)
              2'd0: ph_nxt = 2'd1;
              2'd1: begin
                shift_nxt     = {shift_r[6:0], 1'b0};
                bit_count_nxt = bit_inc;
                ph_nxt        = (bit_inc >= 4'd8) ? 2'd2 : 2'd0;
              end
              2'd2: ph_nxt = 2'd3;
              default: begin
                // end of the acknowledge clock
                ph_nxt = 2'd0;
                case (seg_r)
                  SEG_ADDR_W: begin
                    seg_nxt       = SEG_REG;
                    shift_nxt     = held_reg_r;
                    bit_count_nxt = 4'd0;
                  end
                  SEG_REG: begin
                    if (is_read_r) begin
                      seg_nxt = SEG_START2;
                    end else begin
                      seg_nxt       = SEG_DATA;
                      shift_nxt     = held_data_r;
                      bit_count_nxt = 4'd0;
                    end
                  end
                  SEG_DATA: seg_nxt = SEG_STOP;
                  default: begin
                    seg_nxt       = SEG_READ;
                    shift_nxt     = 8'd0;
                    bit_count_nxt = 4'd0;
                  end
                endcase
              end
            endcase
          end
          SEG_READ: begin
            case (ph_r)
              2'd0: ph_nxt = 2'd1;
              2'd1: begin
                // sample on the last tick of scl high
                shift_nxt     = {shift_r[6:0], q_item.sda_in};
                bit_count_nxt = bit_inc;
                if (bit_inc >= 4'd8) begin
                  recv_nxt = {shift_r[6:0], q_item.sda_in};
                  ph_nxt   = 2'd2;
                end else begin
                  ph_nxt = 2'd0;
                end
              end
              default: begin
                seg_nxt = SEG_STOP;
                ph_nxt  = 2'd0;
              end
            endcase
          end
          SEG_STOP: begin
            if (ph_r != 2'd3) begin
              ph_nxt = ph_r + 2'd1;
            end else begin
              seg_nxt  = SEG_IDLE;
              ph_nxt   = 2'd0;
              done_nxt = 1'b1;
            end
          end
          default: begin
            seg_nxt = SEG_IDLE;
            ph_nxt  = 2'd0;
          end
        endcase
      end
    end
  end

  // bus levels follow the step just entered
  assign bit_out = shift_nxt[7];

  always_comb begin
    scl_nxt = 1'b0;
    sda_nxt = 1'b1;
    drv_nxt = 1'b1;
    case (seg_nxt)
      SEG_START1, SEG_START2: begin
        scl_nxt = (ph_nxt == 2'd1) || (ph_nxt == 2'd2);
        sda_nxt = (ph_nxt == 2'd0) || (ph_nxt == 2'd1);
      end
      SEG_ADDR_W, SEG_REG, SEG_DATA, SEG_ADDR_R: begin
        scl_nxt = ph_nxt[0];
        sda_nxt = ph_nxt[1] ? 1'b1 : bit_out;
        drv_nxt = !ph_nxt[1];
      end
      SEG_READ: begin
        scl_nxt = (ph_nxt == 2'd1);
        drv_nxt = ph_nxt[1];
      end
      SEG_STOP: begin
        scl_nxt = (ph_nxt == 2'd1) || (ph_nxt == 2'd2);
        sda_nxt = ph_nxt[1];
      end
      default: begin
        scl_nxt = 1'b0;
      end
    endcase
  end

  assign busy_nxt      = !((seg_nxt == SEG_IDLE) && (ph_nxt == 2'd0));
  assign rdata_nxt     = recv_nxt;
  assign out_valid_nxt = q_pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= SEG_IDLE;
      ph_r        <= 2'd0;
      bit_count_r <= 4'd0;
      shift_r     <= 8'd0;
      tick_r      <= 16'd0;
      is_read_r   <= 1'b0;
      held_reg_r  <= 8'd0;
      held_data_r <= 8'd0;
      recv_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      seg_r       <= seg_nxt;
      ph_r        <= ph_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      tick_r      <= tick_nxt;
      is_read_r   <= is_read_nxt;
      held_reg_r  <= held_reg_nxt;
      held_data_r <= held_data_nxt;
      recv_r      <= recv_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        drv_r   <= drv_nxt;
        busy_r  <= busy_nxt;
        done_r  <= done_nxt;
        rdata_r <= rdata_nxt;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_level = scl_r;
  assign out_sda_level = sda_r;
  assign out_sda_drive = drv_r;
  assign out_busy_res  = busy_r;
  assign out_done_res  = done_r;
  assign out_read_data = rdata_r;

endmodule

>>> sv/i2c_register_access_master_core.sv
// top level of the i2c register access master: configuration registers,
// front end queue and bus sequencer; depends on i2cram_pkg, i2cram_front, i2cram_seq
//
// Each input beat is one tick of bus time and yields exactly one result beat
// with the SCL/SDA levels for that tick. One beat is taken per clock while the
// input queue has room. The edge that takes an input beat writes it into the
// four-entry input queue; once the beat reaches the head of the queue and the
// output register is free, an edge moves it through the sequencer into the
// output register. The sequencer advances one bus phase each time phase_ticks
// ticks have passed. Commands that arrive while a transaction is in progress
// start none and count as plain ticks. Configuration writes take effect on the
// next edge and should only be made with no beats outstanding.
module i2c_register_access_master_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_reg_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_level,
  output logic        out_sda_level,
  output logic        out_sda_drive,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_read_data
);

  i2cram_pkg::cfg_t  cfg_r, cfg_nxt;
  logic              q_valid;
  logic              q_pop;
  i2cram_pkg::item_t q_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        i2cram_pkg::CFG_DEVICE_ADDRESS: cfg_nxt.device_address = cfg_data[6:0];
        i2cram_pkg::CFG_PHASE_TICKS:    cfg_nxt.phase_ticks    = cfg_data;
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= i2cram_pkg::RESET_DEV_ADDR;
      cfg_r.phase_ticks    <= i2cram_pkg::RESET_PHASE_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  i2cram_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_reg_address (in_reg_address),
    .in_write_data  (in_write_data),
    .in_sda_in      (in_sda_in),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  i2cram_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_sda_drive (out_sda_drive),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_read_data (out_read_data)
  );

endmodule

>>> sv/i2cram_checker.sv
// port-level checks for the i2c register access master, bound to the top level
// no package dependencies
module i2cram_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_scl_level,
  input logic       out_sda_level,
  input logic       out_sda_drive,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic [7:0] out_read_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_scl_level) && $stable(out_done_res))
    else $error("result beat changed while stalled");

  // the stop pulse ends the transaction
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done pulse while still busy");

  // idle bus: scl low, sda driven high
  a_idle_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> !out_scl_level && out_sda_level && out_sda_drive)
    else $error("bus levels wrong while idle");

  // released sda reads back as high
  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sda_drive |-> out_sda_level)
    else $error("sda level low while released");

endmodule

bind i2c_register_access_master_core i2cram_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_scl_level (out_scl_level),
  .out_sda_level (out_sda_level),
  .out_sda_drive (out_sda_drive),
  .out_busy_res  (out_busy_res),
  .out_done_res  (out_done_res),
  .out_read_data (out_read_data)
);
